@@ rtl/bme_pkg.sv @@
`default_nettype none

package bme_pkg;

  // Geometry of the stored set
  localparam int WORDS   = 32;
  localparam int WORD_W  = 32;
  localparam int ADDR_W  = $clog2(WORDS);
  localparam int NW_W    = ADDR_W + 1;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int IDX_W   = 11;
  localparam int CNT_W   = 11;
  localparam int POP_W   = BIT_W + 1;

  localparam logic [IDX_W-1:0] FOUND_NONE = '1;

  typedef enum logic [2:0] {
    CMD_SET       = 3'd0,
    CMD_CLEAR     = 3'd1,
    CMD_TEST      = 3'd2,
    CMD_FIND_NEXT = 3'd3,
    CMD_COUNT     = 3'd4,
    CMD_CLEAR_ALL = 3'd5
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Access request from the sequencer to the word store
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              clr_en;
  } mem_req_t;

  // One result item
  typedef struct packed {
    logic             bad_index;
    logic [CNT_W-1:0] member_count;
    logic [IDX_W-1:0] found_index;
    logic             prior_bit;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/bme_store.sv @@
`default_nettype none

module bme_store import bme_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_req_t          req_i,
  input  logic [NW_W-1:0]   clr_words_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  valid_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rvalid_q;

  // Word array: write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  // Per-word valid bits: an unwritten or cleared word reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[req_i.rd_addr];
      end
      if (req_i.clr_en) begin
        for (int k = 0; k < WORDS; k++) begin
          if (NW_W'(k) < clr_words_i) begin
            valid_q[k] <= 1'b0;
          end
        end
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ rtl/bme_seq.sv @@
`default_nettype none

module bme_seq import bme_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        in_cmd_i,
  input  logic [IDX_W-1:0]  in_idx_i,
  input  logic [NW_W-1:0]   n_words_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output mem_req_t          mem_req_o,
  input  logic [WORD_W-1:0] rd_data_i
);

  // Population count of one word
  function automatic logic [POP_W-1:0] pop32(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = w - ((w >> 1) & 32'h5555_5555);
    v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
    v = (v + (v >> 4)) & 32'h0f0f_0f0f;
    v = v + (v >> 8);
    v = v + (v >> 16);
    return v[POP_W-1:0];
  endfunction

  // Position of the lowest set bit of a nonzero word
  function automatic logic [BIT_W-1:0] ctz32(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] iso;
    logic [BIT_W-1:0]  pos;
    iso = w & (~w + WORD_W'(1));
    pos = '0;
    for (int k = 0; k < WORD_W; k++) begin
      pos = pos | (iso[k] ? BIT_W'(k) : '0);
    end
    return pos;
  endfunction

  state_e            state_q, state_d;
  logic [2:0]        cmd_q;
  logic [IDX_W-1:0]  idx_q;
  logic [ADDR_W-1:0] ptr_q;
  logic              first_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              accept;
  logic              fin, adv;
  logic [IDX_W-1:0]  start_in, start, limit;
  logic [ADDR_W-1:0] addr_in;
  logic              bad_bit, bad_find, empty, last;
  logic [WORD_W-1:0] bit_mask, scan;
  logic [CNT_W-1:0]  sum;

  assign accept = in_valid_i && in_ready_o;

  // Start word of the item being accepted
  assign start_in = in_idx_i + IDX_W'(1);
  always_comb begin
    case (cmd_e'(in_cmd_i))
      CMD_FIND_NEXT: addr_in = start_in[ADDR_W+BIT_W-1:BIT_W];
      CMD_COUNT:     addr_in = '0;
      default:       addr_in = in_idx_i[ADDR_W+BIT_W-1:BIT_W];
    endcase
  end

  // Index checks and word scan for the item at work
  assign limit    = {n_words_i, {BIT_W{1'b0}}};
  assign start    = idx_q + IDX_W'(1);
  assign bad_bit  = idx_q[IDX_W-1] || (idx_q >= limit);
  assign bad_find = (idx_q[IDX_W-1] && (idx_q != FOUND_NONE)) ||
                    (!idx_q[IDX_W-1] && (idx_q >= limit));
  assign empty    = start >= limit;
  assign last     = ({1'b0, ptr_q} + NW_W'(1)) >= n_words_i;
  assign bit_mask = WORD_W'(1) << idx_q[BIT_W-1:0];
  assign scan     = rd_data_i & (first_q ? ({WORD_W{1'b1}} << start[BIT_W-1:0])
                                         : {WORD_W{1'b1}});
  assign sum      = cnt_q + CNT_W'(pop32(rd_data_i));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: if (fin && res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: memory requests and result
  always_comb begin
    in_ready_o          = (state_q == ST_IDLE);
    res_o.prior_bit     = 1'b0;
    res_o.found_index   = FOUND_NONE;
    res_o.member_count  = '0;
    res_o.bad_index     = 1'b0;
    fin                 = 1'b1;
    adv                 = 1'b0;
    mem_req_o.wr_en     = 1'b0;
    mem_req_o.wr_addr   = ptr_q;
    mem_req_o.wr_data   = rd_data_i;
    mem_req_o.clr_en    = 1'b0;
    if (state_q == ST_EXEC) begin
      case (cmd_e'(cmd_q))
        CMD_SET, CMD_CLEAR, CMD_TEST: begin
          if (bad_bit) begin
            res_o.bad_index = 1'b1;
          end else begin
            res_o.prior_bit = |(rd_data_i & bit_mask);
            if (cmd_e'(cmd_q) == CMD_SET) begin
              mem_req_o.wr_en   = 1'b1;
              mem_req_o.wr_data = rd_data_i | bit_mask;
            end else if (cmd_e'(cmd_q) == CMD_CLEAR) begin
              mem_req_o.wr_en   = 1'b1;
              mem_req_o.wr_data = rd_data_i & ~bit_mask;
            end
          end
        end
        CMD_FIND_NEXT: begin
          if (bad_find) begin
            res_o.bad_index = 1'b1;
          end else if (empty) begin
            fin = 1'b1;
          end else if (scan != '0) begin
            res_o.found_index = IDX_W'({ptr_q, ctz32(scan)});
          end else if (!last) begin
            fin = 1'b0;
            adv = 1'b1;
          end
        end
        CMD_COUNT: begin
          if (n_words_i == '0) begin
            fin = 1'b1;
          end else if (last) begin
            res_o.member_count = sum;
          end else begin
            fin = 1'b0;
            adv = 1'b1;
          end
        end
        CMD_CLEAR_ALL: mem_req_o.clr_en = 1'b1;
        default: fin = 1'b1;
      endcase
    end
    res_valid_o       = (state_q == ST_EXEC) && fin;
    mem_req_o.rd_en   = accept || adv;
    mem_req_o.rd_addr = (state_q == ST_IDLE) ? addr_in : ptr_q + ADDR_W'(1);
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the item, then advance the word walk
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_cmd_i;
      idx_q   <= in_idx_i;
      ptr_q   <= addr_in;
      first_q <= 1'b1;
      cnt_q   <= '0;
    end else if (adv) begin
      ptr_q   <= ptr_q + ADDR_W'(1);
      first_q <= 1'b0;
      cnt_q   <= sum;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bitset_membership_engine.sv @@
// Channel  | Dir | Item fields (lowest bit first)
// ---------+-----+---------------------------------------------------------
// s_axis   | in  | cmd[2:0], bit_index[13:3]
// m_axis   | out | prior_bit[0], found_index[11:1], member_count[22:12],
//          |     | bad_index[23]
// cfg      | in  | words_in_use[5:0], written when cfg_we_i is high
//
// Set, clear, test and clear-all accept the item with the word read, then
// give the word result and write-back. Find-next reads W words, W being
// the words walked (at least one), and count reads N words, N being the words
// in use (at least one); the store's single read port gives one word per
// cycle. Reset clears all words at once through per-word valid bits, with
// no sweep. A stalled output register holds the result while the next item
// is already accepted and worked on.
`default_nettype none

module bitset_membership_engine import bme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cmd[2:0], bit_index[13:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // prior_bit, found_index, member_count, bad_index
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i     // words_in_use
);

  logic [5:0]        words_q;
  logic [NW_W-1:0]   n_words;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] rd_data;
  logic              res_valid, res_ready;
  res_t              res;
  logic              out_valid_q;
  res_t              out_q;

  // Words in use register, limited to the store depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= 6'(WORDS);
    end else if (cfg_we_i) begin
      words_q <= cfg_wdata_i;
    end
  end

  assign n_words = (words_q > 6'(WORDS)) ? NW_W'(WORDS) : NW_W'(words_q);

  bme_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tdata[2:0]),
    .in_idx_i    (s_axis_tdata[13:3]),
    .n_words_i   (n_words),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  bme_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .clr_words_i (n_words),
    .rd_data_o   (rd_data)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.bad_index, out_q.member_count,
                          out_q.found_index, out_q.prior_bit};

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while another is at work");

  a_prior_not_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[23])
    else $error("prior bit reported on a bad index");

  a_found_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[11:1] != 11'h7ff) |->
      (m_axis_tdata[22:12] == 11'd0) && !m_axis_tdata[23] && !m_axis_tdata[0])
    else $error("found index mixed with other result fields");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[22:12] <= 11'd1024)
    else $error("member count above set size");
`endif

endmodule

`default_nettype wire

@@ bench/bitset_membership_engine_tb.sv @@
`timescale 1ns / 100ps

module bitset_membership_engine_tb;
  import bme_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int BIT_SPAN   = WORDS * WORD_W;
  localparam int FIND_SPAN  = 2 ** (IDX_W - 1);
  localparam int COUNT_SAT  = 2 ** CNT_W - 1;
  localparam int HOLD_AT    = 60;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN      = 2 * WORDS + 8;
  localparam int PHASE_ITEMS = 160;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // cmd[2:0], bit_index[13:3]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // prior_bit, found_index, member_count, bad_index
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;

  // Predictor state: the stored set and the words-in-use register
  logic [BIT_SPAN-1:0] member_bits = '0;
  int unsigned         words_cfg = 32;

  logic [15:0] cmd_backlog[$];
  res_t        owed_results[$];
  logic        in_taken = 1'b0;
  int          items_in = 0;
  int          mismatches = 0;
  bit          calm = 1'b0;

  int src_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  res_t got_res, want_res;

  bitset_membership_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int active_words();
    return (words_cfg > WORDS) ? WORDS : words_cfg;
  endfunction

  // Apply one command to the predicted set and return its result item
  function automatic res_t predict_membership(logic [2:0] op, logic signed [IDX_W-1:0] pos);
    res_t r;
    int   idx;
    int   lim;
    int   b;
    int   cnt;
    idx = pos;
    lim = active_words() * WORD_W;
    r.prior_bit    = 1'b0;
    r.found_index  = FOUND_NONE;
    r.member_count = '0;
    r.bad_index    = 1'b0;
    case (op)
      CMD_SET, CMD_CLEAR, CMD_TEST: begin
        if (idx < 0 || idx >= lim) begin
          r.bad_index = 1'b1;
        end else begin
          r.prior_bit = member_bits[idx];
          if (op == CMD_SET) member_bits[idx] = 1'b1;
          else if (op == CMD_CLEAR) member_bits[idx] = 1'b0;
        end
      end
      CMD_FIND_NEXT: begin
        if (idx < -1 || idx >= lim) begin
          r.bad_index = 1'b1;
        end else begin
          for (b = idx + 1; b < lim && b < FIND_SPAN; b++) begin
            if (member_bits[b]) begin
              r.found_index = IDX_W'(b);
              break;
            end
          end
        end
      end
      CMD_COUNT: begin
        cnt = 0;
        for (b = 0; b < lim; b++) cnt += member_bits[b];
        if (cnt > COUNT_SAT) cnt = COUNT_SAT;
        r.member_count = CNT_W'(cnt);
      end
      CMD_CLEAR_ALL: begin
        for (b = 0; b < lim; b++) member_bits[b] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_item(logic [2:0] op, int pos);
    cmd_backlog.push_back({2'b00, IDX_W'(pos), op});
  endtask

  // Bias positions toward a small hot window so bits get revisited
  function automatic int pick_position(bit for_find);
    int lim;
    int r;
    lim = active_words() * WORD_W;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 6) return int'($urandom_range(0, 2047)) - 1024;
    if (r < 12) return (for_find && r < 9) ? -1 : lim - 1;
    if (r < 15) return lim;
    if (r < 60) return $urandom_range(0, ((lim < 48) ? lim : 48) - 1);
    return $urandom_range(0, lim - 1);
  endfunction

  task automatic push_random(int n);
    int k;
    int r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) push_item(CMD_SET, pick_position(1'b0));
      else if (r < 47) push_item(CMD_CLEAR, pick_position(1'b0));
      else if (r < 62) push_item(CMD_TEST, pick_position(1'b0));
      else if (r < 86) push_item(CMD_FIND_NEXT, pick_position(1'b1));
      else if (r < 95) push_item(CMD_COUNT, $urandom_range(0, 2047));
      else if (r < 97) push_item(CMD_CLEAR_ALL, $urandom_range(0, 2047));
      else push_item($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7, $urandom_range(0, 2047));
    end
  endtask

  // Block until every queued item went in and every result came back
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || s_axis_tvalid || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_words(int unsigned v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[5:0];
    words_cfg = v & 6'h3f;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sender: hold an offered item until taken, idle in random bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !in_taken)) begin
      if (s_axis_tvalid) void'(cmd_backlog.pop_front());
      if (src_gap > 0 && !calm) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 15);
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd_backlog[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the input
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (!hold_done && items_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0 && !calm) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: check results against the oldest prediction, predict accepted items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = res_t'(m_axis_tdata);
        if (owed_results.size() == 0) begin
          log_mismatch($sformatf("result %h with nothing expected", m_axis_tdata));
        end else begin
          want_res = owed_results.pop_front();
          if (got_res.prior_bit !== want_res.prior_bit)
            log_mismatch($sformatf("prior_bit got %0b want %0b",
                                   got_res.prior_bit, want_res.prior_bit));
          if (got_res.found_index !== want_res.found_index)
            log_mismatch($sformatf("found_index got %0d want %0d",
                                   $signed(got_res.found_index), $signed(want_res.found_index)));
          if (got_res.member_count !== want_res.member_count)
            log_mismatch($sformatf("member_count got %0d want %0d",
                                   got_res.member_count, want_res.member_count));
          if (got_res.bad_index !== want_res.bad_index)
            log_mismatch($sformatf("bad_index got %0b want %0b",
                                   got_res.bad_index, want_res.bad_index));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_results.push_back(predict_membership(s_axis_tdata[2:0], s_axis_tdata[13:3]));
        items_in++;
      end
    end
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Full span at reset: extremes, every command, edge positions
    push_item(CMD_SET, 0);
    push_item(CMD_SET, 1023);
    push_item(CMD_TEST, 1023);
    push_item(CMD_FIND_NEXT, -1);
    push_item(CMD_FIND_NEXT, 0);
    push_item(CMD_FIND_NEXT, 1022);
    push_item(CMD_FIND_NEXT, 1023);
    push_item(CMD_FIND_NEXT, -2);
    push_item(CMD_SET, -1);
    push_item(CMD_TEST, -1024);
    push_item(CMD_CLEAR, 0);
    push_item(CMD_TEST, 0);
    push_item(CMD_COUNT, 0);
    push_item(CMD_SPARE_6, 1023);
    push_item(CMD_SPARE_7, -1);
    push_item(CMD_CLEAR_ALL, -1);
    push_item(CMD_COUNT, 1023);
    push_item(CMD_FIND_NEXT, -1);
    push_random(PHASE_ITEMS);
    wait_idle();

    // One word: last bit in use is valid for find next, one past it is bad
    write_words(1);
    push_item(CMD_SET, 31);
    push_item(CMD_SET, 32);
    push_item(CMD_FIND_NEXT, 31);
    push_item(CMD_FIND_NEXT, 32);
    push_random(PHASE_ITEMS - 40);
    wait_idle();

    // No words in use: every position is bad, find from -1 is not
    write_words(0);
    push_item(CMD_SET, 0);
    push_item(CMD_FIND_NEXT, -1);
    push_item(CMD_COUNT, 0);
    push_random(40);
    wait_idle();

    // Register above the store size clamps to the full store
    write_words(63);
    push_random(PHASE_ITEMS);
    wait_idle();

    write_words($urandom_range(2, 31));
    push_random(PHASE_ITEMS);
    wait_idle();

    // Final stretch at full size with no idling on either side
    write_words(32);
    calm = 1'b1;
    push_random(PHASE_ITEMS);
    wait_idle();

    repeat (DRAIN) @(posedge clk_i);
    if (owed_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", owed_results.size()));
    if (mismatches == 0) begin
      $display("bitset_membership_engine_tb: done, clean");
    end else begin
      $display("bitset_membership_engine_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("bitset_membership_engine_tb: done, errors");
    $finish;
  end

endmodule
